@@ rtl/tac_pkg.sv @@
// Shared constants, codes and types for the thermistor-to-temperature pipeline.
// Used by tac_ln, tac_div and thermistor_adc_to_temperature; depends on nothing.
package tac_pkg;

    localparam int LN_W      = 26;   // ln R in Q20, below 2^25 for any 36-bit argument
    localparam int LN_FRAC   = 20;
    localparam int LOG_STEPS = 24;   // fraction bits of log2
    localparam int LN_LAT    = LOG_STEPS + 2;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int SW  = 49;         // Steinhart-Hart sum width
    localparam int NW  = 50;         // dividend width
    localparam int Q_W = 18;         // quotient bits kept after the overflow check

    localparam logic [Q_W-1:0] Q_MAX = 18'd227315;
    localparam logic signed [18:0] TEMP_MAX = 19'sd200000;
    localparam logic signed [18:0] TEMP_MIN = -19'sd27315;
    localparam logic signed [18:0] KELVIN_CENTI = 19'sd27315;

    localparam logic [1:0] FAULT_OK       = 2'd0;
    localparam logic [1:0] FAULT_ZERO_RES = 2'd1;
    localparam logic [1:0] FAULT_ZERO_SUM = 2'd2;

    localparam logic [1:0] REG_SERIES_R = 2'd0;
    localparam logic [1:0] REG_COEFF_A  = 2'd1;
    localparam logic [1:0] REG_COEFF_B  = 2'd2;
    localparam logic [1:0] REG_COEFF_C  = 2'd3;

    typedef struct packed {
        logic zero_res;
        logic zero_sum;
        logic ovf;
    } div_flags_t;

endpackage

@@ rtl/tac_ln.sv @@
// Pipelined natural logarithm in Q20: normalize, 24 squaring steps, scale by ln 2.
// Depends on tac_pkg.
module tac_ln #(
    parameter int IN_W = 36
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [IN_W-1:0]          x,
    output logic [tac_pkg::LN_W-1:0] y
);
    import tac_pkg::*;

    localparam int KW  = $clog2(IN_W);
    localparam int P_W = KW + LOG_STEPS + 33;

    logic [31:0]          m_reg    [0:LOG_STEPS];
    logic [LOG_STEPS-1:0] frac_reg [0:LOG_STEPS];
    logic [KW-1:0]        k_reg    [0:LOG_STEPS];
    logic [LN_W-1:0]      y_reg;

    logic [KW-1:0] k_lead;
    logic [63:0]   x_wide;
    logic [63:0]   x_norm;

    // Leading one position, then bring it to bit 63; the top word is the Q31 mantissa.
    always_comb
    begin
        k_lead = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (x[i])
            begin
                k_lead = KW'(i);
            end
        end
        x_wide = 64'(x);
        x_norm = x_wide << (6'(63 - int'(k_lead)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= x_norm[63:32];
            frac_reg[0] <= '0;
            k_reg[0]    <= k_lead;
        end
    end

    for (genvar j = 0; j < LOG_STEPS; j++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;
        assign sq = 64'(m_reg[j]) * 64'(m_reg[j]);
        assign t  = sq[63:31];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[j+1]    <= t[32] ? t[32:1] : t[31:0];
                frac_reg[j+1] <= {frac_reg[j][LOG_STEPS-2:0], t[32]};
                k_reg[j+1]    <= k_reg[j];
            end
        end
    end

    logic [P_W-1:0] prod;
    logic [P_W-1:0] rounded;
    assign prod    = P_W'({k_reg[LOG_STEPS], frac_reg[LOG_STEPS]}) * P_W'(LN2_Q32);
    assign rounded = (prod + (P_W'(1) << 35)) >> 36;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= rounded[LN_W-1:0];
        end
    end

    assign y = y_reg;

endmodule

@@ rtl/tac_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with flags riding along.
// Depends on tac_pkg.
module tac_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  tac_pkg::div_flags_t       in_flags,
    input  logic [tac_pkg::NW-1:0]    num,
    input  logic [tac_pkg::SW-1:0]    den,
    output logic                      out_valid,
    output tac_pkg::div_flags_t       out_flags,
    output logic [tac_pkg::Q_W-1:0]   quot
);
    import tac_pkg::*;

    logic             valid_reg [0:Q_W];
    div_flags_t       flags_reg [0:Q_W];
    logic [SW-1:0]    rem_reg   [0:Q_W];
    logic [SW-1:0]    den_reg   [0:Q_W];
    logic [Q_W-1:0]   low_reg   [0:Q_W];
    logic [Q_W-1:0]   q_reg     [0:Q_W];

    logic [NW-1:0] num_hi;
    assign num_hi = num >> Q_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg[0] <= in_flags;
            rem_reg[0]   <= num_hi[SW-1:0];
            den_reg[0]   <= den;
            low_reg[0]   <= num[Q_W-1:0];
            q_reg[0]     <= '0;
        end
    end

    for (genvar i = 0; i < Q_W; i++)
    begin : g_step
        logic [SW:0] trial;
        logic [SW:0] diff;
        logic        ge;
        assign trial = {rem_reg[i], low_reg[i][Q_W-1-i]};
        assign diff  = trial - {1'b0, den_reg[i]};
        assign ge    = (trial >= {1'b0, den_reg[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flags_reg[i+1] <= flags_reg[i];
                rem_reg[i+1]   <= ge ? diff[SW-1:0] : trial[SW-1:0];
                den_reg[i+1]   <= den_reg[i];
                low_reg[i+1]   <= low_reg[i];
                q_reg[i+1]     <= {q_reg[i][Q_W-2:0], ge};
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign out_flags = flags_reg[Q_W];
    assign quot      = q_reg[Q_W];

endmodule

@@ rtl/thermistor_adc_to_temperature.sv @@
// Top level: thermistor ADC code to temperature in 0.01 degC (Steinhart-Hart).
// Depends on tac_pkg, tac_ln and tac_div.
//
//  channel   | signals                              | payload
//  ----------+--------------------------------------+-------------------------------
//  input     | s_tvalid s_tready s_tdata[15:0]      | adc_code [11:0]
//  output    | m_tvalid m_tready m_tdata[23:0]      | temperature_centi_c [18:0]
//            | m_tuser[1:0]                         | fault_code [1:0]
//  config    | cfg_we cfg_addr[1:0] cfg_data[31:0]  | register writes, no read-back
//
// The pipeline takes one request per cycle while not stalled. Its depth is set by
// the 24 squaring steps of the log unit and the 18 quotient-bit stages.
// Every stage moves on one common enable, which is low only while the output holds a
// result that the sink has not taken; nothing is dropped or repeated while stalled.
// Reset clears the valid bits and loads the configuration registers with their defaults.
module thermistor_adc_to_temperature #(
    parameter int ADC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_code, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [18:0] temperature_centi_c, [23:19] zero
    output logic [1:0]  m_tuser,   // [1:0] fault_code
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data
);
    import tac_pkg::*;

    localparam int NUM_W = 20 + ADC_BITS;
    localparam int DEN_W = ADC_BITS + 1;

    // Configuration registers.
    logic [19:0] rs_reg;
    logic [31:0] ca_reg;
    logic [31:0] cb_reg;
    logic [31:0] cc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= 20'd10000;
            ca_reg <= 32'd816920647;
            cb_reg <= 32'd231344943;
            cc_reg <= 32'd134930;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SERIES_R: rs_reg <= cfg_data[19:0];
                REG_COEFF_A:  ca_reg <= cfg_data;
                REG_COEFF_B:  cb_reg <= cfg_data;
                REG_COEFF_C:  cc_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // One enable for the whole pipeline: stall only when the output is full and blocked.
    logic en;
    logic out_valid_reg;
    assign en       = m_tready || !out_valid_reg;
    assign s_tready = en;

    // Stage 0: resistance ratio terms.
    logic [15:0]         code_ext;
    logic [ADC_BITS-1:0] code;
    logic [NUM_W-1:0]    num_next;
    logic [DEN_W-1:0]    den_next;
    assign code_ext = {4'b0, s_tdata[11:0]};
    assign code     = code_ext[ADC_BITS-1:0];
    assign num_next = NUM_W'(rs_reg) * NUM_W'(code);
    assign den_next = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, code};

    logic             v0_reg;
    logic             z0_reg;
    logic [NUM_W-1:0] num0_reg;
    logic [DEN_W-1:0] den0_reg;

    // Natural logs of numerator and denominator run side by side.
    logic [LN_W-1:0] lnum;
    logic [LN_W-1:0] lden;

    tac_ln #(.IN_W(NUM_W)) u_ln_num (.clk(clk), .en(en), .x(num0_reg), .y(lnum));
    tac_ln #(.IN_W(DEN_W)) u_ln_den (.clk(clk), .en(en), .x(den0_reg), .y(lden));

    logic lv_reg [0:LN_LAT-1];
    logic lz_reg [0:LN_LAT-1];

    // Polynomial stages.
    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic            z1_reg, z2_reg, z3_reg, z4_reg, z5_reg, z6_reg, z7_reg;
    logic [LN_W-1:0] l1_reg;
    logic [LN_W-1:0] l2b_reg;
    logic [30:0]     l2_reg;
    logic [35:0]     l3_reg;
    logic [37:0]     bl3_reg;
    logic [37:0]     bl4_reg;
    logic [47:0]     ch_reg;
    logic [31:0]     cl_reg;
    logic [SW-1:0]   p1_reg;
    logic [SW-1:0]   p2_reg;
    logic [SW-1:0]   s6_reg;
    logic [SW-1:0]   s7_reg;
    logic [NW-1:0]   n7_reg;
    logic            zs7_reg;

    logic [LN_W-1:0] l_next;
    logic [51:0]     l2_prod;
    logic [56:0]     l3_prod;
    logic [57:0]     bl_prod;
    logic [47:0]     ch_prod;
    logic [51:0]     cl_prod;
    logic [NW-1:0]   n_next;

    assign l_next  = (lnum > lden) ? (lnum - lden) : '0;
    assign l2_prod = 52'(l1_reg) * 52'(l1_reg);
    assign l3_prod = 57'(l2_reg) * 57'(l2b_reg);
    assign bl_prod = 58'(cb_reg) * 58'(l2b_reg);
    assign ch_prod = 48'(cc_reg) * 48'(l3_reg[35:20]);
    assign cl_prod = 52'(cc_reg) * 52'(l3_reg[19:0]);
    assign n_next  = (NW'(100) << 40) + NW'(s6_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 0; i < LN_LAT; i++)
            begin
                lv_reg[i] <= 1'b0;
            end
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= s_tvalid;
            lv_reg[0] <= v0_reg;
            for (int i = 1; i < LN_LAT; i++)
            begin
                lv_reg[i] <= lv_reg[i-1];
            end
            v1_reg <= lv_reg[LN_LAT-1];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg    <= (num_next == '0);
            num0_reg  <= num_next;
            den0_reg  <= den_next;
            lz_reg[0] <= z0_reg;
            for (int i = 1; i < LN_LAT; i++)
            begin
                lz_reg[i] <= lz_reg[i-1];
            end
            z1_reg  <= lz_reg[LN_LAT-1];
            l1_reg  <= l_next;
            z2_reg  <= z1_reg;
            l2_reg  <= l2_prod[50:20];
            l2b_reg <= l1_reg;
            z3_reg  <= z2_reg;
            l3_reg  <= l3_prod[55:20];
            bl3_reg <= bl_prod[57:20];
            z4_reg  <= z3_reg;
            ch_reg  <= ch_prod;
            cl_reg  <= cl_prod[51:20];
            bl4_reg <= bl3_reg;
            z5_reg  <= z4_reg;
            p1_reg  <= SW'(ca_reg) + SW'(bl4_reg);
            p2_reg  <= SW'(ch_reg) + SW'(cl_reg);
            z6_reg  <= z5_reg;
            s6_reg  <= p1_reg + p2_reg;
            z7_reg  <= z6_reg;
            s7_reg  <= s6_reg;
            n7_reg  <= n_next;
            zs7_reg <= (s6_reg == '0);
        end
    end

    // A quotient of 2^18 or more is certainly beyond the clamp.
    div_flags_t      dflags_in;
    div_flags_t      dflags_out;
    logic [NW-1:0]   n_hi;
    logic            dv_out;
    logic [Q_W-1:0]  quot;

    assign n_hi               = n7_reg >> Q_W;
    assign dflags_in.zero_res = z7_reg;
    assign dflags_in.zero_sum = zs7_reg;
    assign dflags_in.ovf      = (n_hi >= NW'(s7_reg));

    tac_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_flags  (dflags_in),
        .num       (n7_reg),
        .den       (s7_reg),
        .out_valid (dv_out),
        .out_flags (dflags_out),
        .quot      (quot)
    );

    // Output register: fault priority is zero resistance, then zero sum, then clamp.
    logic signed [18:0] temp_next;
    logic [1:0]         fault_next;
    logic signed [18:0] temp_reg;
    logic [1:0]         fault_reg;

    always_comb
    begin
        if (dflags_out.zero_res)
        begin
            temp_next  = TEMP_MIN;
            fault_next = FAULT_ZERO_RES;
        end
        else if (dflags_out.zero_sum)
        begin
            temp_next  = TEMP_MAX;
            fault_next = FAULT_ZERO_SUM;
        end
        else if (dflags_out.ovf || (quot > Q_MAX))
        begin
            temp_next  = TEMP_MAX;
            fault_next = FAULT_OK;
        end
        else
        begin
            temp_next  = $signed({1'b0, quot}) - KELVIN_CENTI;
            fault_next = FAULT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg  <= temp_next;
            fault_reg <= fault_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, temp_reg};
    assign m_tuser  = fault_reg;

    // Checks on the result encoding and the stall path.
    a_zero_res_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == FAULT_ZERO_RES) |-> (temp_reg == TEMP_MIN))
        else $error("zero-resistance fault without minimum temperature");

    a_zero_sum_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == FAULT_ZERO_SUM) |-> (temp_reg == TEMP_MAX))
        else $error("zero-sum fault without maximum temperature");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == FAULT_OK || m_tuser == FAULT_ZERO_RES
                      || m_tuser == FAULT_ZERO_SUM))
        else $error("undefined fault code");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (temp_reg >= TEMP_MIN && temp_reg <= TEMP_MAX))
        else $error("temperature outside its range");

endmodule

@@ tb/tb.sv @@
// Testbench for thermistor_adc_to_temperature: drives ADC code requests, predicts each
// temperature and fault with a bit-exact fixed-point Steinhart-Hart model, and checks results.
// Depends on tac_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
    import tac_pkg::*;

    localparam int FS = 4096;
    localparam int PIPE_LAT = 54;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic signed [18:0] temp;
        logic [1:0]         fault;
    } temp_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;

    // Register copies used by the predictor.
    logic [19:0] rs_ohm;
    logic [31:0] k_a, k_b, k_c;

    logic [11:0]  code_pending[$];
    temp_result_t temp_expected[$];
    logic in_accepted = 1'b0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  error_count = 0;
    int  result_count = 0;
    int  fault_count[3] = '{0, 0, 0};
    longint cycle_count = 0;

    thermistor_adc_to_temperature i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Natural log in Q20 via repeated squaring of a Q31 mantissa.
    function automatic logic [63:0] ln_q20(logic [63:0] x);
        int k;
        logic [63:0] m, frac, log2q;
        logic [127:0] p;
        k = 0;
        frac = 0;
        for (int b = 0; b < 64; b++)
            if (x[b]) k = b;
        if (k > 31) m = x >> (k - 31);
        else m = x << (31 - k);
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        log2q = (64'(k) << 24) | frac;
        p = 128'(log2q) * 128'(LN2_Q32) + (128'd1 << 35);
        return 64'(p >> 36);
    endfunction

    function automatic temp_result_t predict_temp(logic [11:0] code);
        temp_result_t r;
        logic [63:0] num, den, lnum, lden, l1, l2, l3, q;
        logic [127:0] s;
        num = 64'(rs_ohm) * 64'(code);
        if (num == 0)
        begin
            r.temp = TEMP_MIN;
            r.fault = FAULT_ZERO_RES;
            return r;
        end
        den = 64'(FS - code);
        lnum = ln_q20(num);
        lden = ln_q20(den);
        l1 = (lnum > lden) ? lnum - lden : 0;
        l2 = (l1 * l1) >> 20;
        l3 = (l2 * l1) >> 20;
        s = 128'(k_a) + ((128'(k_b) * 128'(l1)) >> 20) + ((128'(k_c) * 128'(l3)) >> 20);
        if (s == 0)
        begin
            r.temp = TEMP_MAX;
            r.fault = FAULT_ZERO_SUM;
            return r;
        end
        q = 64'(((128'd100 << 40) + (s >> 1)) / s);
        if (q > 64'(Q_MAX)) r.temp = TEMP_MAX;
        else r.temp = 19'(q) - KELVIN_CENTI;
        r.fault = FAULT_OK;
        return r;
    endfunction

    // Driver: presents the oldest pending code; the valid is only lowered
    // once the current request has gone. Acceptance is taken from the last rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_accepted)
                void'(code_pending.pop_front());
            if (!(s_tvalid && !in_accepted))
            begin
                if (code_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, code_pending[0]};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    s_tdata <= 16'($urandom);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predictions are made when a request is accepted, in order.
    always @(posedge clk)
    begin
        in_accepted <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            temp_expected.push_back(predict_temp(s_tdata[11:0]));
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge clk)
    begin
        temp_result_t exp_r;
        cycle_count <= cycle_count + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count <= result_count + 1;
            if (temp_expected.size() == 0)
            begin
                $display("%0t: unexpected result temp=%0d fault=%0d", $time,
                         $signed(m_tdata[18:0]), m_tuser);
                error_count <= error_count + 1;
            end
            else
            begin
                exp_r = temp_expected.pop_front();
                fault_count[exp_r.fault] <= fault_count[exp_r.fault] + 1;
                if (m_tdata[18:0] !== exp_r.temp || m_tdata[23:19] !== 5'b0)
                begin
                    $display("%0t: temperature expected %0d, actual %0d (raw %h)", $time,
                             exp_r.temp, $signed(m_tdata[18:0]), m_tdata);
                    error_count <= error_count + 1;
                end
                if (m_tuser !== exp_r.fault)
                begin
                    $display("%0t: fault expected %0d, actual %0d", $time,
                             exp_r.fault, m_tuser);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle limit with %0d results outstanding",
                     temp_expected.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SERIES_R: rs_ohm = val[19:0];
            REG_COEFF_A:  k_a = val;
            REG_COEFF_B:  k_b = val;
            default:      k_c = val;
        endcase
    endtask

    // Waits for all outstanding requests and results, then for the pipeline to drain.
    task automatic drain_pipe();
        while (code_pending.size() > 0 || s_tvalid || temp_expected.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // Random code, biased toward the ends of the scale where the divider is extreme.
    function automatic logic [11:0] rand_code();
        case ($urandom_range(9))
            0:       return 12'($urandom_range(8));
            1:       return 12'($urandom_range(4095, 4087));
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            code_pending.push_back(rand_code());
        drain_pipe();
    endtask

    initial
    begin
        rs_ohm = 20'd10000;
        k_a = 32'd816920647;
        k_b = 32'd231344943;
        k_c = 32'd134930;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed codes with reset coefficients: zero code, full scale, every bit.
        code_pending.push_back(12'd0);
        code_pending.push_back(12'd1);
        code_pending.push_back(12'd4095);
        code_pending.push_back(12'd2048);
        code_pending.push_back(12'hAAA);
        code_pending.push_back(12'h555);
        for (int b = 0; b < 12; b++)
            code_pending.push_back(12'(1 << b));
        drain_pipe();

        // Zero series resistor forces the zero-resistance fault for any code.
        write_reg(REG_SERIES_R, 32'd0);
        code_pending.push_back(12'd4095);
        code_pending.push_back(12'd100);
        drain_pipe();

        // Zero coefficients give a zero sum; a tiny constant term is too hot.
        write_reg(REG_SERIES_R, 32'd1);
        write_reg(REG_COEFF_A, 32'd0);
        write_reg(REG_COEFF_B, 32'd0);
        write_reg(REG_COEFF_C, 32'd0);
        code_pending.push_back(12'd1);
        code_pending.push_back(12'd4095);
        drain_pipe();
        write_reg(REG_COEFF_A, 32'd1);
        code_pending.push_back(12'd3000);
        drain_pipe();

        // Largest resistor and coefficients: very cold readings.
        write_reg(REG_SERIES_R, 32'hFFFFF);
        write_reg(REG_COEFF_A, 32'hFFFFFFFF);
        write_reg(REG_COEFF_B, 32'hFFFFFFFF);
        write_reg(REG_COEFF_C, 32'hFFFFFFFF);
        code_pending.push_back(12'd4095);
        code_pending.push_back(12'd1);
        drain_pipe();

        // Back to a typical sensor, through every idling mix.
        write_reg(REG_SERIES_R, 32'd10000);
        write_reg(REG_COEFF_A, 32'd816920647);
        write_reg(REG_COEFF_B, 32'd231344943);
        write_reg(REG_COEFF_C, 32'd134930);
        random_phase(400, 0, 0);
        random_phase(300, 65, 0);
        random_phase(300, 0, 65);
        random_phase(300, 37, 37);

        // Random register settings, each with a short run of codes.
        for (int p = 0; p < 11; p++)
        begin
            write_reg(REG_SERIES_R, 32'($urandom_range(1000000, 1)) | 32'($urandom) << 20);
            write_reg(REG_COEFF_A, $urandom_range(1) ? $urandom : $urandom_range(2000000000));
            write_reg(REG_COEFF_B, $urandom_range(1) ? $urandom : $urandom_range(500000000));
            write_reg(REG_COEFF_C, $urandom_range(1) ? $urandom : $urandom_range(1000000));
            random_phase(50, (p % 4 == 1 || p % 4 == 3) ? 37 : 0,
                         (p % 4 >= 2) ? 65 : 0);
        end

        $display("Checked %0d results: %0d ok, %0d zero resistance, %0d zero sum",
                 result_count, fault_count[0], fault_count[1], fault_count[2]);
        $display("Run covered register extremes, random settings and four idling mixes.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/tac_pkg.sv
rtl/tac_ln.sv
rtl/tac_div.sv
rtl/thermistor_adc_to_temperature.sv
tb/tb.sv
